@@ hdl/spab_pkg.sv @@
// shared types, constants and arithmetic helpers for the scaled pixel alpha blend
package spab_pkg;

	// apb port geometry
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// full-scale channel value and unity in q0.8
	localparam logic [7:0] CH_MAX = 8'd255;
	localparam logic [8:0] ONE_Q8 = 9'd256;

	typedef logic [7:0] chan_t;
	typedef logic [3:0][7:0] argb_t;

	// channel positions inside an argb word
	localparam int CH_B = 0;
	localparam int CH_G = 1;
	localparam int CH_R = 2;
	localparam int CH_A = 3;

	// register index taken from paddr[2]
	typedef enum logic [0:0] {
		REG_GLOBAL_ALPHA    = 1'b0,
		REG_BILINEAR_ENABLE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		chan_t global_alpha;
		logic  bilinear_enable;
	} spab_cfg_t;

	// interpolated sample handed from the filter to the blender
	typedef struct packed {
		argb_t dst;
		argb_t smp;
		logic  en;
	} spab_mid_t;

	// exact floor(x / 255) for x up to 255*255, shift-and-add form
	function automatic chan_t div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

@@ hdl/spab_item_if.sv @@
// input channel carrying one destination pixel and its four source samples
interface spab_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] dst_pixel;
	logic [31:0] src_top_left;
	logic [31:0] src_top_right;
	logic [31:0] src_bottom_left;
	logic [31:0] src_bottom_right;
	logic [7:0]  frac_x;
	logic [7:0]  frac_y;
	logic        pixel_enable;

	modport source (
		output valid, dst_pixel, src_top_left, src_top_right, src_bottom_left,
		       src_bottom_right, frac_x, frac_y, pixel_enable,
		input  ready
	);

	modport sink (
		input  valid, dst_pixel, src_top_left, src_top_right, src_bottom_left,
		       src_bottom_right, frac_x, frac_y, pixel_enable,
		output ready
	);
endinterface

@@ hdl/spab_result_if.sv @@
// output channel carrying one composited pixel
interface spab_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;
	logic        write_enable;

	modport source (
		output valid, out_pixel, write_enable,
		input  ready
	);

	modport sink (
		input  valid, out_pixel, write_enable,
		output ready
	);
endinterface

@@ hdl/spab_cfg.sv @@
// apb register file holding global alpha and the filter mode
module spab_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [spab_pkg::ADDR_W-1:0] paddr,
	input  logic [spab_pkg::DATA_W-1:0] pwdata,
	output logic [spab_pkg::DATA_W-1:0] prdata,
	output logic                     pready,
	output spab_pkg::spab_cfg_t      cfg
);
	import spab_pkg::*;

	chan_t    global_alpha_q;
	logic     bilinear_enable_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_alpha_q    <= CH_MAX;
			bilinear_enable_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_GLOBAL_ALPHA:    global_alpha_q    <= pwdata[7:0];
				REG_BILINEAR_ENABLE: bilinear_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GLOBAL_ALPHA:    prdata = {{(DATA_W-8){1'b0}}, global_alpha_q};
			REG_BILINEAR_ENABLE: prdata = {{(DATA_W-1){1'b0}}, bilinear_enable_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.global_alpha    = global_alpha_q;
	assign cfg.bilinear_enable = bilinear_enable_q;

endmodule

@@ hdl/spab_interp.sv @@
// two-stage bilinear filter: row sums, then the vertical mix
module spab_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  spab_pkg::spab_cfg_t cfg,
	spab_item_if.sink           pixel,
	output logic                mid_valid,
	input  logic                mid_ready,
	output spab_pkg::spab_mid_t mid
);
	import spab_pkg::*;

	logic              v_s1, v_s2;
	logic              ld1, ld2;
	logic [3:0][15:0]  top_s1, bot_s1;
	logic [7:0]        v_frac_s1;
	argb_t             dst_s1;
	logic              en_s1;
	argb_t             smp_s2;
	argb_t             dst_s2;
	logic              en_s2;

	argb_t             tl, tr, bl, br;
	logic [7:0]        u_eff, v_eff;
	logic [3:0][15:0]  top_d, bot_d;
	argb_t             smp_d;

	assign tl = pixel.src_top_left;
	assign tr = pixel.src_top_right;
	assign bl = pixel.src_bottom_left;
	assign br = pixel.src_bottom_right;

	// nearest mode is bilinear with both fractions at zero
	assign u_eff = cfg.bilinear_enable ? pixel.frac_x : 8'd0;
	assign v_eff = cfg.bilinear_enable ? pixel.frac_y : 8'd0;

	// stage handshake: a stage loads when empty or when its successor loads
	assign ld2         = !v_s2 || mid_ready;
	assign ld1         = !v_s1 || ld2;
	assign pixel.ready = ld1;

	// horizontal row sums, each fits 16 bits
	always_comb begin
		logic [17:0] t, b;
		for (int c = 0; c < 4; c++) begin
			t = {9'd0, tl[c]} * {9'd0, ONE_Q8 - {1'b0, u_eff}} + {10'd0, tr[c]} * {10'd0, u_eff};
			b = {9'd0, bl[c]} * {9'd0, ONE_Q8 - {1'b0, u_eff}} + {10'd0, br[c]} * {10'd0, u_eff};
			top_d[c] = t[15:0];
			bot_d[c] = b[15:0];
		end
	end

	// vertical mix, result taken from bits 23:16
	always_comb begin
		logic [24:0] m;
		for (int c = 0; c < 4; c++) begin
			m = {9'd0, top_s1[c]} * {16'd0, ONE_Q8 - {1'b0, v_frac_s1}}
			  + {9'd0, bot_s1[c]} * {17'd0, v_frac_s1};
			smp_d[c] = m[23:16];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= pixel.valid;
			if (ld2) v_s2 <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld1 && pixel.valid) begin
			top_s1    <= top_d;
			bot_s1    <= bot_d;
			v_frac_s1 <= v_eff;
			dst_s1    <= pixel.dst_pixel;
			en_s1     <= pixel.pixel_enable;
		end
		if (ld2 && v_s1) begin
			smp_s2 <= smp_d;
			dst_s2 <= dst_s1;
			en_s2  <= en_s1;
		end
	end

	assign mid_valid = v_s2;
	assign mid.dst   = dst_s2;
	assign mid.smp   = smp_s2;
	assign mid.en    = en_s2;

`ifndef ASSERT_OFF
	// a stalled row-sum stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ld2) |=> (v_s1 && $stable(top_s1) && $stable(dst_s1)))
		else $error("stage 1 item changed while stalled");

	// a stalled mix stage keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !mid_ready) |=> (v_s2 && $stable(smp_s2) && $stable(dst_s2)))
		else $error("stage 2 item changed while stalled");
`endif

endmodule

@@ hdl/spab_blend.sv @@
// four-stage source-over blender: alpha scale, alpha divide, mix, divide and select
module spab_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  spab_pkg::spab_cfg_t cfg,
	input  logic                mid_valid,
	output logic                mid_ready,
	input  spab_pkg::spab_mid_t mid,
	spab_result_if.source       result
);
	import spab_pkg::*;

	logic             v_s3, v_s4, v_s5, v_s6;
	logic             ld3, ld4, ld5, ld6;

	logic [15:0]      pa_s3;
	logic [2:0][7:0]  rgb_s3, rgb_s4;
	argb_t            dst_s3, dst_s4, dst_s5;
	logic             en_s3, en_s4, en_s5;
	chan_t            sa_s4, sa_s5;
	logic [2:0][15:0] mix_s5;
	logic [15:0]      dsa_s5;
	logic [31:0]      out_s6;
	logic             we_s6;

	chan_t            ia;
	logic [2:0][15:0] mix_d;
	argb_t            res_d;

	// stage handshake chain from the output back
	assign ld6       = !v_s6 || result.ready;
	assign ld5       = !v_s5 || ld6;
	assign ld4       = !v_s4 || ld5;
	assign ld3       = !v_s3 || ld4;
	assign mid_ready = ld3;

	// inverse source alpha and weighted colour sums
	assign ia = CH_MAX - sa_s4;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix_d[c] = {8'd0, rgb_s4[c]} * {8'd0, sa_s4} + {8'd0, dst_s4[c]} * {8'd0, ia};
		end
	end

	// final divide and alpha composite
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			res_d[c] = div255(mix_s5[c]);
		end
		res_d[CH_A] = sa_s5 + div255(dsa_s5);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld3) v_s3 <= mid_valid;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld3 && mid_valid) begin
			pa_s3  <= {8'd0, mid.smp[CH_A]} * {8'd0, cfg.global_alpha};
			rgb_s3 <= mid.smp[2:0];
			dst_s3 <= mid.dst;
			en_s3  <= mid.en;
		end
		if (ld4 && v_s3) begin
			sa_s4  <= div255(pa_s3);
			rgb_s4 <= rgb_s3;
			dst_s4 <= dst_s3;
			en_s4  <= en_s3;
		end
		if (ld5 && v_s4) begin
			mix_s5 <= mix_d;
			dsa_s5 <= {8'd0, dst_s4[CH_A]} * {8'd0, ia};
			sa_s5  <= sa_s4;
			dst_s5 <= dst_s4;
			en_s5  <= en_s4;
		end
		if (ld6 && v_s5) begin
			out_s6 <= en_s5 ? res_d : dst_s5;
			we_s6  <= en_s5;
		end
	end

	assign result.valid        = v_s6;
	assign result.out_pixel    = out_s6;
	assign result.write_enable = we_s6;

`ifndef ASSERT_OFF
	// a stalled alpha-scale stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ld4) |=> (v_s3 && $stable(pa_s3) && $stable(dst_s3)))
		else $error("stage 3 item changed while stalled");

	// a stalled mix stage keeps its item
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !ld6) |=> (v_s5 && $stable(mix_s5) && $stable(sa_s5)))
		else $error("stage 5 item changed while stalled");
`endif

endmodule

@@ hdl/scaled_pixel_alpha_blend.sv @@
// top level of the scaled pixel alpha blend compositing core
//
// pixel: one transfer per pixel carrying the destination ARGB word, the four
// source samples around the sample point, the q0.8 fractions and the enable bit.
// result: one transfer per input pixel, in order, with the composited word and
// write_enable; a disabled pixel returns its destination word with write_enable low.
// apb port: global_alpha at byte address 0, bilinear_enable at 4; write only
// while no pixel is in flight.
// throughput: one pixel per clock cycle while result is ready, set by the six-register
// pipeline (two filter stages, four blend stages) that every stage keeps full.
// each pixel is registered in both filter stages and all four blend stages in order.
// when result is stalled each stage holds its item; a stage still takes a new
// item as long as some stage between it and the output is empty, so up to six
// pixels sit in the pipeline and ready on pixel drops only when all are full.
// reset empties the pipeline, sets global_alpha to 255 and selects nearest
// sampling.
module scaled_pixel_alpha_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	spab_item_if.sink                   pixel,
	spab_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [spab_pkg::ADDR_W-1:0] paddr,
	input  logic [spab_pkg::DATA_W-1:0] pwdata,
	output logic [spab_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import spab_pkg::*;

	spab_cfg_t cfg;
	logic      mid_valid;
	logic      mid_ready;
	spab_mid_t mid;

	// configuration registers
	spab_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sample filter
	spab_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pixel     (pixel),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	// compositing
	spab_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.result    (result)
	);

`ifndef ASSERT_OFF
	// with the output stage empty every stage can load, so input must be ready
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> pixel.ready)
		else $error("input stalled with an empty output stage");
`endif

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the scaled pixel alpha blend core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spab_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	// one pixel transfer and one composited result
	typedef struct {
		argb_t dst;
		argb_t tl;
		argb_t tr;
		argb_t bl;
		argb_t br;
		chan_t fx;
		chan_t fy;
		logic  en;
	} pixel_item_t;

	typedef struct {
		argb_t pixel;
		logic  we;
	} blend_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	spab_item_if pix();
	spab_result_if res();

	pixel_item_t pending_pixels[$];
	blend_result_t expected_blends[$];
	spab_cfg_t shadow_cfg;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	int blend_errors;
	int cycle_count;

	scaled_pixel_alpha_blend dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected composite of one pixel under the given register settings
	function automatic blend_result_t composite_pixel(pixel_item_t px, spab_cfg_t cfg);
		int unsigned smp[4];
		int unsigned a, b, c, d, u, v, top, bot, sa, ia, ga;
		int ch;
		blend_result_t r;
		if (!px.en) begin
			r.pixel = px.dst;
			r.we = 1'b0;
			return r;
		end
		u = px.fx;
		v = px.fy;
		ga = cfg.global_alpha;
		// source sample per channel, filtered or top-left
		for (ch = CH_B; ch <= CH_A; ch++) begin
			a = px.tl[ch];
			if (cfg.bilinear_enable) begin
				b = px.tr[ch];
				c = px.bl[ch];
				d = px.br[ch];
				top = a * (ONE_Q8 - u) + b * u;
				bot = c * (ONE_Q8 - u) + d * u;
				smp[ch] = ((top * (ONE_Q8 - v) + bot * v) >> 16) & CH_MAX;
			end else begin
				smp[ch] = a;
			end
		end
		// source-over with global opacity, truncating divisions
		sa = (smp[CH_A] * ga) / CH_MAX;
		ia = CH_MAX - sa;
		for (ch = CH_B; ch <= CH_R; ch++) begin
			a = px.dst[ch];
			r.pixel[ch] = chan_t'((smp[ch] * sa + a * ia) / CH_MAX);
		end
		a = px.dst[CH_A];
		r.pixel[CH_A] = chan_t'(sa + (a * ia) / CH_MAX);
		r.we = 1'b1;
		return r;
	endfunction

	function automatic pixel_item_t make_pixel(argb_t dst, argb_t tl, argb_t tr, argb_t bl,
			argb_t br, chan_t fx, chan_t fy, logic en);
		pixel_item_t it;
		it.dst = dst;
		it.tl = tl;
		it.tr = tr;
		it.bl = bl;
		it.br = br;
		it.fx = fx;
		it.fy = fy;
		it.en = en;
		return it;
	endfunction

	// channel values lean towards the extremes
	function automatic chan_t rand_chan();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	function automatic argb_t rand_argb();
		argb_t px;
		int ch;
		if ($urandom_range(3) == 0) begin
			px = $urandom;
		end else begin
			for (ch = CH_B; ch <= CH_A; ch++)
				px[ch] = rand_chan();
		end
		return px;
	endfunction

	// neighbours are sometimes edge-clamped copies of the top-left sample
	function automatic pixel_item_t rand_pixel();
		pixel_item_t it;
		it.dst = rand_argb();
		it.tl = rand_argb();
		it.tr = ($urandom_range(4) == 0) ? it.tl : rand_argb();
		it.bl = ($urandom_range(4) == 0) ? it.tl : rand_argb();
		it.br = ($urandom_range(4) == 0) ? it.tl : rand_argb();
		it.fx = rand_chan();
		it.fy = rand_chan();
		it.en = ($urandom_range(9) != 0);
		return it;
	endfunction

	// apb write: setup then access, register taken at the access edge
	task automatic apb_write(reg_idx_t idx, chan_t value);
		logic [DATA_W-1:0] wdata;
		wdata = $urandom;
		if (idx == REG_GLOBAL_ALPHA)
			wdata[7:0] = value;
		else
			wdata[0] = value[0];
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_GLOBAL_ALPHA)
			shadow_cfg.global_alpha = wdata[7:0];
		else
			shadow_cfg.bilinear_enable = wdata[0];
	endtask

	task automatic set_config(chan_t ga, logic bil);
		apb_write(REG_GLOBAL_ALPHA, ga);
		apb_write(REG_BILINEAR_ENABLE, {7'd0, bil});
		@(negedge clk);
	endtask

	task automatic queue_random(int n, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (n) pending_pixels.push_back(rand_pixel());
	endtask

	// wait until every pixel is sent and every result is back
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || pix.valid || expected_blends.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// pixel driver
	always @(posedge clk) begin : pixel_driver
		pixel_item_t it;
		if (arst_n && (!pix.valid || pix.ready)) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_pixels.pop_front();
				pix.dst_pixel <= it.dst;
				pix.src_top_left <= it.tl;
				pix.src_top_right <= it.tr;
				pix.src_bottom_left <= it.bl;
				pix.src_bottom_right <= it.br;
				pix.frac_x <= it.fx;
				pix.frac_y <= it.fy;
				pix.pixel_enable <= it.en;
				pix.valid <= 1'b1;
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// result sink ready, held low during a hold-off
	always @(posedge clk) begin
		if (!arst_n || stall_left != 0)
			res.ready <= 1'b0;
		else
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hold-off counter
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	// monitor: check results, then predict newly accepted pixels
	always @(posedge clk) begin : blend_monitor
		blend_result_t want;
		pixel_item_t seen;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (expected_blends.size() == 0) begin
					$error("unexpected result transfer: out_pixel %h write_enable %b",
						res.out_pixel, res.write_enable);
					blend_errors++;
				end else begin
					want = expected_blends.pop_front();
					if (res.out_pixel !== want.pixel) begin
						$error("out_pixel: expected %h, actual %h", want.pixel, res.out_pixel);
						blend_errors++;
					end
					if (res.write_enable !== want.we) begin
						$error("write_enable: expected %b, actual %b", want.we,
							res.write_enable);
						blend_errors++;
					end
				end
			end
			if (pix.valid && pix.ready) begin
				seen = make_pixel(pix.dst_pixel, pix.src_top_left, pix.src_top_right,
					pix.src_bottom_left, pix.src_bottom_right, pix.frac_x, pix.frac_y,
					pix.pixel_enable);
				expected_blends.push_back(composite_pixel(seen, shadow_cfg));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("scaled_pixel_alpha_blend: mismatch");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix.valid = 1'b0;
		pix.dst_pixel = '0;
		pix.src_top_left = '0;
		pix.src_top_right = '0;
		pix.src_bottom_left = '0;
		pix.src_bottom_right = '0;
		pix.frac_x = '0;
		pix.frac_y = '0;
		pix.pixel_enable = 1'b0;
		res.ready = 1'b0;
		shadow_cfg = {CH_MAX, 1'b0};
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_left = 0;
		blend_errors = 0;
		cycle_count = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: nearest sampling, full opacity
		pending_pixels.push_back(make_pixel('0, '0, '0, '0, '0, 8'h00, 8'h00, 1'b1));
		pending_pixels.push_back(make_pixel('1, '1, '1, '1, '1, 8'hFF, 8'hFF, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'h55, 8'hAA, 1'b0));
		pending_pixels.push_back(make_pixel(32'h80402010, 32'hFFC08001, rand_argb(),
			rand_argb(), rand_argb(), 8'h00, 8'h00, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), 32'h00FFFFFF, rand_argb(),
			rand_argb(), rand_argb(), 8'h40, 8'h40, 1'b1));
		// neighbours and fractions must not matter here
		pending_pixels.push_back(make_pixel(rand_argb(), 32'h7F123456, '1, '0, '1,
			8'hFF, 8'h80, 1'b1));
		queue_random(60, 0, 0);
		wait_drained();

		// fully transparent source in bilinear mode
		set_config(8'h00, 1'b1);
		pending_pixels.push_back(make_pixel('1, '1, '1, '1, '1, 8'hFF, 8'hFF, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'h33, 8'hCC, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'h33, 8'hCC, 1'b0));
		queue_random(60, 0, 0);
		wait_drained();

		// bilinear at full opacity: fraction corners
		set_config(8'hFF, 1'b1);
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'h00, 8'h00, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'hFF, 8'h00, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'h00, 8'hFF, 1'b1));
		pending_pixels.push_back(make_pixel('1, '1, '1, '1, '1, 8'hFF, 8'hFF, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), '0, '0, '0, '1, 8'hFF, 8'hFF, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), 32'hFF000000, 32'h00FF0000,
			32'h0000FF00, 32'h000000FF, 8'h80, 8'h80, 1'b1));
		pending_pixels.push_back(make_pixel(rand_argb(), rand_argb(), rand_argb(),
			rand_argb(), rand_argb(), 8'h80, 8'h80, 1'b0));
		pending_pixels.push_back(make_pixel('0, '0, '0, '0, '0, 8'h00, 8'h00, 1'b1));
		queue_random(100, 0, 0);
		wait_drained();

		// sparse sender
		set_config(rand_chan(), 1'b1);
		queue_random(200, 81, 0);
		wait_drained();

		// slow receiver, nearest sampling
		set_config(chan_t'($urandom_range(255)), 1'b0);
		queue_random(150, 0, 81);
		wait_drained();

		// light idling on both sides, pause until drained, then a long hold-off
		set_config(chan_t'($urandom_range(255)), 1'b1);
		queue_random(120, 7, 7);
		wait_drained();
		queue_random(120, 7, 7);
		stall_left = HOLD_OFF_CYCLES;
		wait_drained();

		// near-zero opacity, back to back
		set_config(8'h01, 1'b1);
		queue_random(80, 0, 0);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (blend_errors == 0 && expected_blends.size() == 0) begin
			$display("scaled_pixel_alpha_blend: match");
		end else begin
			$display("scaled_pixel_alpha_blend: mismatch");
		end
		$finish;
	end

endmodule
